// File: sv/bounded_stack_with_sort_top_macros.svh
// Assertion macros for the stack checker file, bss_monitor.
`ifndef BOUNDED_STACK_WITH_SORT_TOP_MACROS_SVH
`define BOUNDED_STACK_WITH_SORT_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define BSS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stack check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define BSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stack check failed");

`endif

// File: sv/bss_pkg.sv
// Shared types and codes for the bounded stack with sort.
package bss_pkg;

  localparam int DATA_W  = 32;
  localparam int COUNT_W = 5;

  localparam logic [1:0] REQ_PUSH = 2'd0;
  localparam logic [1:0] REQ_POP  = 2'd1;
  localparam logic [1:0] REQ_SORT = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_SLOAD,
    S_SCMP,
    S_SPLACE
  } state_t;

  typedef struct packed {
    logic               done;
    logic [1:0]         status;
    logic [DATA_W-1:0]  popped;
    logic [COUNT_W-1:0] count;
    logic               full;
    logic               empty;
  } result_t;

endpackage

// File: sv/bss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/bss_ctrl.sv
// Request sequencer: stack pointer, insertion-sort walk and result register.
module bss_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [1:0]                  req_type,
  input  logic [bss_pkg::DATA_W-1:0]  push_value,
  output logic                        busy,
  output logic                        mem_we,
  output logic [$clog2(DEPTH)-1:0]    mem_waddr,
  output logic [bss_pkg::DATA_W-1:0]  mem_wdata,
  output logic [$clog2(DEPTH)-1:0]    mem_raddr,
  input  logic [bss_pkg::DATA_W-1:0]  mem_rdata,
  output bss_pkg::result_t            res
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CntW = bss_pkg::COUNT_W;

  bss_pkg::state_t  state, state_next;
  bss_pkg::result_t res_next;
  logic [CW-1:0]    count, count_next;
  logic [CW-1:0]    idx_i, i_next;
  logic [CW-1:0]    i_inc;
  logic [CW-1:0]    cnt_inc, cnt_dec;
  logic [AW-1:0]    idx_j, j_next;
  logic [bss_pkg::DATA_W-1:0] key, key_next;

  function automatic bss_pkg::result_t mk_result(input logic [1:0] st,
                                                 input logic [bss_pkg::DATA_W-1:0] pv,
                                                 input logic [CW-1:0] cnt);
    bss_pkg::result_t r;
    r.done   = 1'b1;
    r.status = st;
    r.popped = pv;
    r.count  = CntW'(cnt);
    r.full   = (cnt == CW'(DEPTH));
    r.empty  = (cnt == '0);
    return r;
  endfunction

  assign busy    = (state != bss_pkg::S_IDLE);
  assign i_inc   = idx_i + CW'(1);
  assign cnt_inc = count + CW'(1);
  assign cnt_dec = count - CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bss_pkg::S_IDLE;
      count    <= '0;
      res.done <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      res   <= res_next;
    end
    idx_i <= i_next;
    idx_j <= j_next;
    key   <= key_next;
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    i_next        = idx_i;
    j_next        = idx_j;
    key_next      = key;
    res_next      = res;
    res_next.done = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = idx_j;
    mem_wdata     = key;
    mem_raddr     = idx_j - AW'(1);

    unique case (state)
      bss_pkg::S_IDLE: begin
        if (start) begin
          case (req_type)
            bss_pkg::REQ_PUSH: begin
              if (count == CW'(DEPTH)) begin
                res_next = mk_result(bss_pkg::STAT_OVERFLOW, '0, count);
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = count[AW-1:0];
                mem_wdata  = push_value;
                count_next = cnt_inc;
                res_next   = mk_result(bss_pkg::STAT_OK, '0, cnt_inc);
              end
            end
            bss_pkg::REQ_POP: begin
              if (count == '0) begin
                res_next = mk_result(bss_pkg::STAT_UNDERFLOW, '0, count);
              end else begin
                count_next = cnt_dec;
                mem_raddr  = cnt_dec[AW-1:0];
                state_next = bss_pkg::S_POP;
              end
            end
            bss_pkg::REQ_SORT: begin
              if (count < CW'(2)) begin
                res_next = mk_result(bss_pkg::STAT_OK, '0, count);
              end else begin
                i_next     = CW'(1);
                mem_raddr  = AW'(1);
                state_next = bss_pkg::S_SLOAD;
              end
            end
            default: begin
              res_next = mk_result(bss_pkg::STAT_OK, '0, count);
            end
          endcase
        end
      end
      bss_pkg::S_POP: begin
        res_next   = mk_result(bss_pkg::STAT_OK, mem_rdata, count);
        state_next = bss_pkg::S_IDLE;
      end
      bss_pkg::S_SLOAD: begin
        key_next   = mem_rdata;
        j_next     = idx_i[AW-1:0];
        mem_raddr  = idx_i[AW-1:0] - AW'(1);
        state_next = bss_pkg::S_SCMP;
      end
      bss_pkg::S_SCMP: begin
        mem_we    = 1'b1;
        mem_waddr = idx_j;
        if ($signed(mem_rdata) > $signed(key)) begin
          // shift the larger entry up and keep walking down
          mem_wdata = mem_rdata;
          j_next    = idx_j - AW'(1);
          mem_raddr = idx_j - AW'(2);
          if (idx_j == AW'(1)) begin
            state_next = bss_pkg::S_SPLACE;
          end
        end else begin
          mem_wdata = key;
          if (i_inc == count) begin
            res_next   = mk_result(bss_pkg::STAT_OK, '0, count);
            state_next = bss_pkg::S_IDLE;
          end else begin
            i_next     = i_inc;
            mem_raddr  = i_inc[AW-1:0];
            state_next = bss_pkg::S_SLOAD;
          end
        end
      end
      bss_pkg::S_SPLACE: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = key;
        if (i_inc == count) begin
          res_next   = mk_result(bss_pkg::STAT_OK, '0, count);
          state_next = bss_pkg::S_IDLE;
        end else begin
          i_next     = i_inc;
          mem_raddr  = i_inc[AW-1:0];
          state_next = bss_pkg::S_SLOAD;
        end
      end
      default: begin
        state_next = bss_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/bounded_stack_with_sort_top.sv
// Top level of the bounded stack with in-place insertion sort.
//
// Requests enter on start/req_type/push_value and are taken when start is
// high and busy is low. Each transaction yields exactly one result, shown on
// status/popped_value/entry_count/is_full/is_empty for one cycle while done
// is high; the receiver cannot stall, so results must be taken as shown.
// Push, failed pop, unused code and sort of fewer than two entries report
// in the cycle after acceptance and leave busy low, so such requests
// can be issued every cycle. A successful pop reports from S_POP, after
// the registered memory read and then the result register. A sort walks
// the memory through its separate write and read ports in S_SLOAD, S_SCMP
// and S_SPLACE, shifting larger entries up, with busy high until it reports.
// Reset clears the entry count and control; stored values are not cleared
// and no clearing pass runs, since only written entries are ever read.
module bounded_stack_with_sort_top #(
  parameter int DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [1:0]                         req_type,
  input  logic signed [bss_pkg::DATA_W-1:0]  push_value,
  output logic                               busy,
  output logic                               done,
  output logic [1:0]                         status,
  output logic signed [bss_pkg::DATA_W-1:0]  popped_value,
  output logic [bss_pkg::COUNT_W-1:0]        entry_count,
  output logic                               is_full,
  output logic                               is_empty
);

  localparam int AW = $clog2(DEPTH);

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [AW-1:0]              mem_raddr;
  logic [bss_pkg::DATA_W-1:0] mem_wdata;
  logic [bss_pkg::DATA_W-1:0] mem_rdata;
  bss_pkg::result_t           res;

  bss_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .req_type   (req_type),
    .push_value (push_value),
    .busy       (busy),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .res        (res)
  );

  bss_ram #(
    .WIDTH (bss_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign done         = res.done;
  assign status       = res.status;
  assign popped_value = res.popped;
  assign entry_count  = res.count;
  assign is_full      = res.full;
  assign is_empty     = res.empty;

endmodule

// File: sv/bss_monitor.sv
// Port-level checks for the bounded stack, bound to the top level.
`include "bounded_stack_with_sort_top_macros.svh"

module bss_monitor (
  input logic                               clk,
  input logic                               rst,
  input logic                               start,
  input logic [1:0]                         req_type,
  input logic                               busy,
  input logic                               done,
  input logic [1:0]                         status,
  input logic signed [bss_pkg::DATA_W-1:0]  popped_value,
  input logic [bss_pkg::COUNT_W-1:0]        entry_count,
  input logic                               is_full,
  input logic                               is_empty
);

  `BSS_ASSERT_NEXT(a_push_done, start && !busy && req_type == bss_pkg::REQ_PUSH, done && !busy)
  `BSS_ASSERT_NOW(a_under_empty, done && status == bss_pkg::STAT_UNDERFLOW, is_empty && popped_value == 0)
  `BSS_ASSERT_NOW(a_over_full, done && status == bss_pkg::STAT_OVERFLOW, is_full && !is_empty)
  `BSS_ASSERT_NOW(a_empty_count, done && is_empty, entry_count == 0 && !is_full)

endmodule

bind bounded_stack_with_sort_top bss_monitor u_bss_monitor (.*);
